// ----- design/gfpm_pkg.sv -----
// Shared types and constants for the gated frequency / period meter.
package gfpm_pkg;

  localparam int FIELD_W        = 24;
  localparam int LEN_W          = 8;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [FIELD_W-1:0] FIELD_MAX     = {FIELD_W{1'b1}};
  localparam logic [LEN_W-1:0]   GATE_LEN_RST  = 8'd20;
  localparam logic [LEN_W-1:0]   PRESS_LEN_RST = 8'd20;
  localparam logic [FIELD_W-1:0] NUMER_RST     = 24'd1000000;
  localparam logic [FIELD_W-1:0] PERIOD_RST    = 24'd50;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NUMER = 2'd2;

  // Per-item word handed from the front to the back (count travels beside it).
  typedef struct packed {
    logic [FIELD_W-1:0] shown;
    logic [FIELD_W-1:0] live;
    logic               led;
    logic               done;
  } job_t;

endpackage

// ----- design/gfpm_front.sv -----
// Front end: accepts words, runs pulse/tick/press counters, queues a job per word.
module gfpm_front #(
  parameter int COUNT_WIDTH = gfpm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic                         in_hold,
  input  logic                         in_button_held,
  input  logic [gfpm_pkg::LEN_W-1:0]   gate_length,
  input  logic [gfpm_pkg::LEN_W-1:0]   press_length,
  input  logic                         q_full,
  output logic                         q_push,
  output gfpm_pkg::job_t               q_job,
  output logic [COUNT_WIDTH-1:0]       q_count
);
  import gfpm_pkg::*;

  localparam int XW = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;

  logic [COUNT_WIDTH-1:0] pulse_count_r, pulse_count_nxt;
  logic [LEN_W-1:0]       tick_count_r, tick_count_nxt;
  logic [LEN_W-1:0]       press_count_r, press_count_nxt;
  logic [FIELD_W-1:0]     shown_r, shown_nxt;
  logic [FIELD_W-1:0]     live_r, live_nxt;
  logic                   led_r, led_nxt;
  logic                   accept;
  logic                   done;
  logic [LEN_W-1:0]       tick_inc;
  logic [LEN_W-1:0]       press_inc;
  logic [XW-1:0]          cnt_ext;
  logic [FIELD_W-1:0]     cnt_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign tick_inc  = tick_count_r + LEN_W'(1);
  assign press_inc = press_count_r + LEN_W'(1);
  assign cnt_ext   = XW'(pulse_count_r);
  assign cnt_sat   = (cnt_ext > XW'(FIELD_MAX)) ? FIELD_MAX : cnt_ext[FIELD_W-1:0];

  always_comb begin
    pulse_count_nxt = pulse_count_r;
    tick_count_nxt  = tick_count_r;
    press_count_nxt = press_count_r;
    shown_nxt       = shown_r;
    live_nxt        = live_r;
    led_nxt         = led_r;
    done            = 1'b0;
    if (in_op == OP_PULSE) begin
      if (pulse_count_r != {COUNT_WIDTH{1'b1}}) begin
        pulse_count_nxt = pulse_count_r + COUNT_WIDTH'(1);
      end
    end else begin
      if (in_button_held) begin
        if (press_inc >= press_length) begin
          led_nxt         = ~led_r;
          press_count_nxt = '0;
        end else begin
          press_count_nxt = press_inc;
        end
      end else begin
        press_count_nxt = '0;
      end
      tick_count_nxt = tick_inc;
      if (tick_inc >= gate_length) begin
        done            = 1'b1;
        live_nxt        = cnt_sat;
        if (!in_hold) begin
          shown_nxt = cnt_sat;
        end
        pulse_count_nxt = '0;
        tick_count_nxt  = '0;
      end
    end
  end

  assign q_push      = accept;
  assign q_job.shown = shown_nxt;
  assign q_job.live  = live_nxt;
  assign q_job.led   = led_nxt;
  assign q_job.done  = done;
  assign q_count     = pulse_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= '0;
      tick_count_r  <= '0;
      press_count_r <= '0;
      shown_r       <= '0;
      live_r        <= '0;
      led_r         <= 1'b1;
    end else if (accept) begin
      pulse_count_r <= pulse_count_nxt;
      tick_count_r  <= tick_count_nxt;
      press_count_r <= press_count_nxt;
      shown_r       <= shown_nxt;
      live_r        <= live_nxt;
      led_r         <= led_nxt;
    end
  end

endmodule

// ----- design/gfpm_queue.sv -----
// Small FIFO between the front end and the back end.
module gfpm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import gfpm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

// ----- design/gfpm_back.sv -----
// Back end: period division (restoring, one bit per cycle) and output register.
module gfpm_back #(
  parameter int COUNT_WIDTH = gfpm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  gfpm_pkg::job_t                q_job,
  input  logic [COUNT_WIDTH-1:0]        q_count,
  input  logic [gfpm_pkg::FIELD_W-1:0]  period_numerator,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gfpm_pkg::FIELD_W-1:0]  out_shown_frequency,
  output logic [gfpm_pkg::FIELD_W-1:0]  out_live_frequency,
  output logic [gfpm_pkg::FIELD_W-1:0]  out_period_value,
  output logic                          out_led_enabled,
  output logic                          out_gate_done
);
  import gfpm_pkg::*;

  localparam int RW     = COUNT_WIDTH + 1;
  localparam int STEP_W = $clog2(FIELD_W + 1);

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t                 state_r;
  job_t                   job_r;
  logic [COUNT_WIDTH-1:0] div_r;
  logic [FIELD_W-1:0]     num_r;
  logic [RW-1:0]          rem_r;
  logic [STEP_W-1:0]      step_r;
  logic [FIELD_W-1:0]     period_r;
  logic                   out_valid_r;
  logic                   out_free;
  logic                   need_div;
  logic                   load_out;
  logic [RW-1:0]          rem_sh;
  logic                   q_bit;
  logic [RW-1:0]          rem_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && !q_empty && out_free;
  assign need_div = q_job.done && (q_count != '0);
  assign load_out = (q_pop && !need_div) ||
                    ((state_r == S_DIV) && (step_r == '0) && out_free);
  assign rem_sh   = {rem_r[RW-2:0], num_r[FIELD_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, div_r});
  assign rem_nxt  = q_bit ? (rem_sh - {1'b0, div_r}) : rem_sh;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      period_r    <= PERIOD_RST;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (need_div) begin
              job_r   <= q_job;
              div_r   <= q_count;
              num_r   <= period_numerator;
              rem_r   <= '0;
              step_r  <= STEP_W'(FIELD_W);
              state_r <= S_DIV;
            end else begin
              out_shown_frequency <= q_job.shown;
              out_live_frequency  <= q_job.live;
              out_led_enabled     <= q_job.led;
              out_gate_done       <= q_job.done;
              if (q_job.done) begin
                period_r         <= period_numerator;
                out_period_value <= period_numerator;
              end else begin
                out_period_value <= period_r;
              end
            end
          end
        end
        S_DIV: begin
          if (step_r != '0) begin
            rem_r  <= rem_nxt;
            num_r  <= {num_r[FIELD_W-2:0], q_bit};
            step_r <= step_r - STEP_W'(1);
          end else if (out_free) begin
            out_shown_frequency <= job_r.shown;
            out_live_frequency  <= job_r.live;
            out_led_enabled     <= job_r.led;
            out_gate_done       <= job_r.done;
            out_period_value    <= num_r;
            period_r            <= num_r;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/gated_frequency_period_meter_unit.sv -----
// Top level of the gated frequency / period meter.
//
// Input words (in_valid/in_stall) are pulse edges or base ticks; every word
// yields exactly one output word (out_valid/out_stall) with the shown and
// live frequency, the period, the LED enable and a gate-closed flag.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// gate length, long-press length and period numerator; cfg_ready is always
// high and writes are expected while the block is idle.
// A word that does not close a gate, or closes one with a zero count, passes
// through the queue into the output register; a gate-closing word with a
// nonzero count also runs through the bit-serial divider (24 quotient bits,
// one per cycle) in the back end.
// Throughput: one word per cycle between gate closes; a 4-entry queue lets
// the front keep accepting while the divider runs, and in_stall rises only
// when that queue is full.
// Reset (synchronous, rst_n low) clears counters and queue, sets the period
// to 50 and the LED enable to 1, and restores the default configuration.
// While out_stall is high the output word holds; the queue then fills and
// stalls the input.
module gated_frequency_period_meter_unit #(
  parameter int COUNT_WIDTH = gfpm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic                            in_hold,
  input  logic                            in_button_held,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gfpm_pkg::FIELD_W-1:0]    out_shown_frequency,
  output logic [gfpm_pkg::FIELD_W-1:0]    out_live_frequency,
  output logic [gfpm_pkg::FIELD_W-1:0]    out_period_value,
  output logic                            out_led_enabled,
  output logic                            out_gate_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gfpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfpm_pkg::FIELD_W-1:0]    cfg_data
);
  import gfpm_pkg::*;

  localparam int QW = $bits(job_t) + COUNT_WIDTH;

  logic [LEN_W-1:0]       gate_length_r;
  logic [LEN_W-1:0]       press_length_r;
  logic [FIELD_W-1:0]     period_numer_r;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;
  job_t                   f_job;
  logic [COUNT_WIDTH-1:0] f_count;
  logic [QW-1:0]          q_wdata;
  logic [QW-1:0]          q_rdata;
  job_t                   b_job;
  logic [COUNT_WIDTH-1:0] b_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_length_r  <= GATE_LEN_RST;
      press_length_r <= PRESS_LEN_RST;
      period_numer_r <= NUMER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GATE_LENGTH:  gate_length_r  <= cfg_data[LEN_W-1:0];
        CFG_PRESS_LENGTH: press_length_r <= cfg_data[LEN_W-1:0];
        CFG_PERIOD_NUMER: period_numer_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gfpm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_hold        (in_hold),
    .in_button_held (in_button_held),
    .gate_length    (gate_length_r),
    .press_length   (press_length_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (f_job),
    .q_count        (f_count)
  );

  assign q_wdata = {f_job, f_count};

  gfpm_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign b_job   = q_rdata[QW-1:COUNT_WIDTH];
  assign b_count = q_rdata[COUNT_WIDTH-1:0];

  gfpm_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_job               (b_job),
    .q_count             (b_count),
    .period_numerator    (period_numer_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_shown_frequency (out_shown_frequency),
    .out_live_frequency  (out_live_frequency),
    .out_period_value    (out_period_value),
    .out_led_enabled     (out_led_enabled),
    .out_gate_done       (out_gate_done)
  );

endmodule

// ----- dv/gated_frequency_period_meter_unit_test.sv -----
// Self-checking testbench for the gated frequency / period meter unit.
`timescale 1ns / 1ps

module gated_frequency_period_meter_unit_test;
  import gfpm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [FIELD_W-1:0] shown;
    logic [FIELD_W-1:0] live;
    logic [FIELD_W-1:0] period;
    logic               led;
    logic               done;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = OP_PULSE;
  logic                 in_hold = 1'b0;
  logic                 in_button_held = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_shown_frequency;
  logic [FIELD_W-1:0]   out_live_frequency;
  logic [FIELD_W-1:0]   out_period_value;
  logic                 out_led_enabled;
  logic                 out_gate_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GATE_LENGTH;
  logic [FIELD_W-1:0]   cfg_data = '0;

  // meter state as predicted
  logic [LEN_W-1:0]   gate_ticks;
  logic [LEN_W-1:0]   press_ticks;
  logic [FIELD_W-1:0] numerator;
  logic [FIELD_W-1:0] pulses_seen;
  logic [LEN_W-1:0]   ticks_seen;
  logic [LEN_W-1:0]   held_ticks;
  logic [FIELD_W-1:0] shown_hz;
  logic [FIELD_W-1:0] live_hz;
  logic [FIELD_W-1:0] period_us;
  logic               led_on;

  reading_t expected_readings[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic long_hold = 1'b0;
  int  mismatches = 0;
  int  words_sent = 0;
  int  readings_checked = 0;
  int  gates_closed = 0;
  int  cycle_count = 0;

  gated_frequency_period_meter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_hold             (in_hold),
    .in_button_held      (in_button_held),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_shown_frequency (out_shown_frequency),
    .out_live_frequency  (out_live_frequency),
    .out_period_value    (out_period_value),
    .out_led_enabled     (out_led_enabled),
    .out_gate_done       (out_gate_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void reset_meter();
    gate_ticks  = GATE_LEN_RST;
    press_ticks = PRESS_LEN_RST;
    numerator   = NUMER_RST;
    pulses_seen = '0;
    ticks_seen  = '0;
    held_ticks  = '0;
    shown_hz    = '0;
    live_hz     = '0;
    period_us   = PERIOD_RST;
    led_on      = 1'b1;
  endfunction

  function automatic reading_t predict_reading(logic op, logic hold, logic button);
    reading_t r;
    r.done = 1'b0;
    if (op == OP_PULSE) begin
      if (pulses_seen != FIELD_MAX) pulses_seen = pulses_seen + 1'b1;
    end else begin
      if (button) begin
        held_ticks = held_ticks + 1'b1;
        if (held_ticks >= press_ticks) begin
          led_on = ~led_on;
          held_ticks = '0;
        end
      end else begin
        held_ticks = '0;
      end
      ticks_seen = ticks_seen + 1'b1;
      if (ticks_seen >= gate_ticks) begin
        live_hz = pulses_seen;
        if (!hold) shown_hz = live_hz;
        period_us = (pulses_seen == '0) ? numerator : numerator / pulses_seen;
        pulses_seen = '0;
        ticks_seen = '0;
        r.done = 1'b1;
      end
    end
    r.shown  = shown_hz;
    r.live   = live_hz;
    r.period = period_us;
    r.led    = led_on;
    return r;
  endfunction

  // predict on every accepted word, check every accepted reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_readings.push_back(predict_reading(in_op, in_hold, in_button_held));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("reading with no word pending");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (want.done) gates_closed++;
          if (out_shown_frequency !== want.shown) begin
            $error("shown_frequency: expected %0d, actual %0d", want.shown, out_shown_frequency);
            mismatches++;
          end
          if (out_live_frequency !== want.live) begin
            $error("live_frequency: expected %0d, actual %0d", want.live, out_live_frequency);
            mismatches++;
          end
          if (out_period_value !== want.period) begin
            $error("period_value: expected %0d, actual %0d", want.period, out_period_value);
            mismatches++;
          end
          if (out_led_enabled !== want.led) begin
            $error("led_enabled: expected %0d, actual %0d", want.led, out_led_enabled);
            mismatches++;
          end
          if (out_gate_done !== want.done) begin
            $error("gate_done: expected %0d, actual %0d", want.done, out_gate_done);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_word(input logic op, input logic hold, input logic button);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_hold        <= hold;
    in_button_held <= button;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic wait_all_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GATE_LENGTH:  gate_ticks  = data[LEN_W-1:0];
      CFG_PRESS_LENGTH: press_ticks = data[LEN_W-1:0];
      CFG_PERIOD_NUMER: numerator   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_segment(input int n, input logic [LEN_W-1:0] gate,
                             input logic [LEN_W-1:0] press, input logic [FIELD_W-1:0] numer,
                             input int tick_pct, input int flip_pct);
    logic button;
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, gate);
    write_reg(CFG_PRESS_LENGTH, press);
    write_reg(CFG_PERIOD_NUMER, numer);
    button = 1'b1;
    repeat (n) begin
      if ($urandom_range(99) < flip_pct) button = ~button;
      if ($urandom_range(99) < tick_pct)
        send_word(OP_TICK, $urandom_range(99) < 25, button);
      else
        send_word(OP_PULSE, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_reset_state();
    send_word(OP_PULSE, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
  endtask

  task automatic test_directed_cases();
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, 2);
    write_reg(CFG_PRESS_LENGTH, 2);
    write_reg(CFG_PERIOD_NUMER, FIELD_MAX);
    send_word(OP_PULSE, 1'b0, 1'b0);
    send_word(OP_PULSE, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b1);
    send_word(OP_TICK, 1'b0, 1'b1);
    // empty gate
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    // hold freezes shown, pulse ignores hold/button
    send_word(OP_PULSE, 1'b1, 1'b1);
    send_word(OP_PULSE, 1'b1, 1'b1);
    send_word(OP_PULSE, 1'b1, 1'b1);
    send_word(OP_TICK, 1'b1, 1'b1);
    send_word(OP_TICK, 1'b1, 1'b0);
    // release clears the press count
    send_word(OP_TICK, 1'b0, 1'b1);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b1);
    // zero lengths, tiny numerator
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, 0);
    write_reg(CFG_PRESS_LENGTH, 0);
    write_reg(CFG_PERIOD_NUMER, 1);
    send_word(OP_TICK, 1'b0, 1'b1);
    send_word(OP_PULSE, 1'b0, 1'b0);
    send_word(OP_PULSE, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    // gate shortened below a running tick count
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, 5);
    write_reg(CFG_PRESS_LENGTH, 255);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    send_word(OP_TICK, 1'b0, 1'b0);
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, 1);
    send_word(OP_TICK, 1'b0, 1'b0);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    logic [LEN_W-1:0]   gate;
    logic [LEN_W-1:0]   press;
    logic [FIELD_W-1:0] numer;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      case ($urandom_range(3))
        0:       gate = 1;
        1, 2:    gate = LEN_W'($urandom_range(8, 2));
        default: gate = LEN_W'($urandom_range(255, 9));
      endcase
      press = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(255, 1))
                                       : LEN_W'($urandom_range(8, 1));
      case ($urandom_range(3))
        0:       numer = 1;
        1:       numer = FIELD_MAX;
        default: numer = FIELD_W'($urandom_range(FIELD_MAX, 1));
      endcase
      run_segment(60, gate, press, numer, 40, 15);
    end
  endtask

  task automatic test_long_lengths();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(300, 255, 255, FIELD_MAX, 90, 0);
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_all_readings();
    write_reg(CFG_GATE_LENGTH, 1);
    write_reg(CFG_PRESS_LENGTH, 3);
    write_reg(CFG_PERIOD_NUMER, FIELD_W'($urandom_range(FIELD_MAX, 1)));
    fork
      begin
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    repeat (40) send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
    // sender waits for every reading before going on
    wait_all_readings();
    repeat (20) send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
  endtask

  initial begin
    reset_meter();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_random_phase(36, 49);
    test_random_phase(49, 36);
    test_back_pressure();
    test_random_phase(0, 0);
    test_long_lengths();
    wait_all_readings();
    repeat (40) @(posedge clk);
    if (expected_readings.size() != 0) mismatches++;
    $display("Covered %0d words and %0d readings, %0d of them closing a gate,",
             words_sent, readings_checked, gates_closed);
    $display("across zero/extreme lengths, hold, long press and output back pressure.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
